// ===== src/zzg_pkg.sv =====
`default_nettype none
package zzg_pkg;
    localparam int DATA_W        = 32;
    localparam int FRAC_BITS_DEF = 16;
    localparam int ACC_W         = 104;
    localparam int MUL_A_W       = 36;
    localparam int MUL_B_W       = 33;
    localparam int MUL_P_W       = MUL_A_W + MUL_B_W;
    localparam int ADDR_W        = 5;
    localparam int DIV_STEPS     = 32;

    localparam logic [2:0] REG_GRAV_X     = 3'd0;
    localparam logic [2:0] REG_GRAV_Y     = 3'd1;
    localparam logic [2:0] REG_GRAV_Z     = 3'd2;
    localparam logic [2:0] REG_TIME_STEP  = 3'd3;
    localparam logic [2:0] REG_FINAL_TIME = 3'd4;

    localparam logic [31:0] TIME_STEP_RST  = 32'd65536;
    localparam logic [31:0] FINAL_TIME_RST = 32'd6553600;
    localparam logic [31:0] ACC_MAX        = 32'h7FFF_FFFF;
    localparam logic [31:0] ACC_MIN        = 32'h8000_0000;

    typedef struct packed {
        logic signed [31:0] grav_x;
        logic signed [31:0] grav_y;
        logic signed [31:0] grav_z;
        logic [31:0]        time_step;
        logic [31:0]        final_time;
    } t_cfg;

    typedef struct packed {
        logic       load_in;
        logic       tgo;
        logic       t2;
        logic       st_a;
        logic       st_b;
        logic       st_c;
        logic       st_d;
        logic       st_e;
        logic       st_f;
        logic       div;
        logic       store;
        logic       emit;
        logic [1:0] axis;
    } t_cmd;

    typedef struct packed {
        logic out_free;
    } t_sts;
endpackage
`default_nettype wire

// ===== src/zzg_if.sv =====
`default_nettype none
interface zzg_in_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] lander_pos_x;
    logic signed [31:0] lander_pos_y;
    logic signed [31:0] lander_pos_z;
    logic signed [31:0] lander_vel_x;
    logic signed [31:0] lander_vel_y;
    logic signed [31:0] lander_vel_z;
    logic signed [31:0] target_pos_x;
    logic signed [31:0] target_pos_y;
    logic signed [31:0] target_pos_z;
    logic signed [31:0] target_vel_x;
    logic signed [31:0] target_vel_y;
    logic signed [31:0] target_vel_z;

    modport source (
        output valid, lander_pos_x, lander_pos_y, lander_pos_z,
               lander_vel_x, lander_vel_y, lander_vel_z,
               target_pos_x, target_pos_y, target_pos_z,
               target_vel_x, target_vel_y, target_vel_z,
        input  ready
    );
    modport sink (
        input  valid, lander_pos_x, lander_pos_y, lander_pos_z,
               lander_vel_x, lander_vel_y, lander_vel_z,
               target_pos_x, target_pos_y, target_pos_z,
               target_vel_x, target_vel_y, target_vel_z,
        output ready
    );
endinterface

interface zzg_out_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] accel_x;
    logic signed [31:0] accel_y;
    logic signed [31:0] accel_z;
    logic [31:0]        time_to_go;
    logic               saturated;

    modport source (
        output valid, accel_x, accel_y, accel_z, time_to_go, saturated,
        input  ready
    );
    modport sink (
        input  valid, accel_x, accel_y, accel_z, time_to_go, saturated,
        output ready
    );
endinterface
`default_nettype wire

// ===== src/zzg_ctrl.sv =====
`default_nettype none
module zzg_ctrl (
    input  wire            i_clk,
    input  wire            i_rst_n,
    input  wire            i_in_fire,
    input  zzg_pkg::t_sts  i_sts,
    output logic           o_in_ready,
    output zzg_pkg::t_cmd  o_cmd
);
    import zzg_pkg::*;

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_TGO  = 4'd1;
    localparam logic [3:0] S_T2   = 4'd2;
    localparam logic [3:0] S_A    = 4'd3;
    localparam logic [3:0] S_B    = 4'd4;
    localparam logic [3:0] S_C    = 4'd5;
    localparam logic [3:0] S_D    = 4'd6;
    localparam logic [3:0] S_E    = 4'd7;
    localparam logic [3:0] S_F    = 4'd8;
    localparam logic [3:0] S_DIV  = 4'd9;
    localparam logic [3:0] S_STO  = 4'd10;
    localparam logic [3:0] S_EMIT = 4'd11;

    localparam logic [4:0] DIV_LAST = 5'(DIV_STEPS - 1);

    logic [3:0] r_state, n_state;
    logic [1:0] r_axis, n_axis;
    logic [4:0] r_cnt, n_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_axis  <= '0;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_axis  <= n_axis;
            r_cnt   <= n_cnt;
        end
    end

    always_comb begin
        n_state    = r_state;
        n_axis     = r_axis;
        n_cnt      = r_cnt;
        o_cmd      = '0;
        o_cmd.axis = r_axis;
        o_in_ready = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready  = 1'b1;
                o_cmd.load_in = i_in_fire;
                if (i_in_fire) n_state = S_TGO;
            end
            S_TGO: begin
                o_cmd.tgo = 1'b1;
                n_state   = S_T2;
            end
            S_T2: begin
                o_cmd.t2 = 1'b1;
                n_axis   = '0;
                n_state  = S_A;
            end
            S_A: begin
                o_cmd.st_a = 1'b1;
                n_state    = S_B;
            end
            S_B: begin
                o_cmd.st_b = 1'b1;
                n_state    = S_C;
            end
            S_C: begin
                o_cmd.st_c = 1'b1;
                n_state    = S_D;
            end
            S_D: begin
                o_cmd.st_d = 1'b1;
                n_state    = S_E;
            end
            S_E: begin
                o_cmd.st_e = 1'b1;
                n_state    = S_F;
            end
            S_F: begin
                o_cmd.st_f = 1'b1;
                n_cnt      = '0;
                n_state    = S_DIV;
            end
            S_DIV: begin
                o_cmd.div = 1'b1;
                n_cnt     = r_cnt + 5'd1;
                if (r_cnt == DIV_LAST) n_state = S_STO;
            end
            S_STO: begin
                o_cmd.store = 1'b1;
                if (r_axis == 2'd2) begin
                    n_state = S_EMIT;
                end else begin
                    n_axis  = r_axis + 2'd1;
                    n_state = S_A;
                end
            end
            S_EMIT: begin
                if (i_sts.out_free) begin
                    o_cmd.emit = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end
endmodule
`default_nettype wire

// ===== src/zzg_datapath.sv =====
`default_nettype none
module zzg_datapath #(
    parameter int FRAC_BITS = zzg_pkg::FRAC_BITS_DEF
) (
    input  wire            i_clk,
    input  wire            i_rst_n,
    input  zzg_pkg::t_cfg  i_cfg,
    input  zzg_pkg::t_cmd  i_cmd,
    output zzg_pkg::t_sts  o_sts,
    zzg_in_if.sink         i_in,
    zzg_out_if.source      o_out
);
    import zzg_pkg::*;

    localparam int SH1 = FRAC_BITS;
    localparam int SH2 = 2 * FRAC_BITS;

    logic signed [31:0] r_lp [3];
    logic signed [31:0] r_lv [3];
    logic signed [31:0] r_tp [3];
    logic signed [31:0] r_tv [3];
    logic [31:0]        r_elapsed;
    logic [31:0]        r_tgo;
    logic [63:0]        r_t2;
    logic signed [MUL_P_W-1:0] r_prod;
    logic signed [ACC_W-1:0]   r_acc;
    logic [ACC_W-1:0]   r_mag;
    logic               r_neg;
    logic               r_big;
    logic [63:0]        r_rem;
    logic [31:0]        r_lo;
    logic [31:0]        r_q;
    logic [31:0]        r_res [3];
    logic               r_sat;
    logic               r_out_valid;
    logic [31:0]        r_out_ax, r_out_ay, r_out_az, r_out_tgo;
    logic               r_out_sat;

    logic [32:0]               sum;
    logic signed [31:0]        g_sel;
    logic signed [32:0]        d_pos;
    logic signed [35:0]        d6;
    logic signed [33:0]        v_sum;
    logic signed [MUL_A_W-1:0] mul_a;
    logic signed [MUL_B_W-1:0] mul_b;
    logic signed [MUL_P_W-1:0] mul_p;
    logic signed [ACC_W-1:0]   prod_ext;
    logic signed [ACC_W-1:0]   d6_ext;
    logic [64:0]               rem_sh;
    logic [64:0]               rem_diff;
    logic                      rem_ge;
    logic [31:0]               res;
    logic                      res_sat;

    assign sum   = {1'b0, r_elapsed} + {1'b0, i_cfg.time_step};
    assign g_sel = (i_cmd.axis == 2'd0) ? i_cfg.grav_x :
                   (i_cmd.axis == 2'd1) ? i_cfg.grav_y : i_cfg.grav_z;
    assign d_pos = 33'(r_tp[i_cmd.axis]) - 33'(r_lp[i_cmd.axis]);
    assign d6    = (36'(d_pos) <<< 2) + (36'(d_pos) <<< 1);
    assign v_sum = (34'(r_lv[i_cmd.axis]) <<< 1) + 34'(r_tv[i_cmd.axis]);
    assign d6_ext   = ACC_W'(d6) <<< SH2;
    assign prod_ext = ACC_W'(r_prod);

    always_comb begin
        mul_a = '0;
        mul_b = '0;
        if (i_cmd.t2) begin
            mul_a = $signed({4'd0, r_tgo});
            mul_b = $signed({1'b0, r_tgo});
        end else if (i_cmd.st_a) begin
            mul_a = MUL_A_W'(v_sum) <<< 1;
            mul_b = $signed({1'b0, r_tgo});
        end else if (i_cmd.st_b) begin
            mul_a = MUL_A_W'(g_sel);
            mul_b = $signed({1'b0, r_t2[31:0]});
        end else if (i_cmd.st_c) begin
            mul_a = MUL_A_W'(g_sel);
            mul_b = $signed({1'b0, r_t2[63:32]});
        end
    end
    assign mul_p = mul_a * mul_b;

    assign rem_sh   = {r_rem, r_lo[31]};
    assign rem_diff = rem_sh - {1'b0, r_t2};
    assign rem_ge   = rem_sh >= {1'b0, r_t2};

    always_comb begin
        res     = r_q;
        res_sat = 1'b0;
        if (r_tgo == '0) begin
            res_sat = 1'b1;
            res     = r_neg ? ACC_MIN : ((r_mag == '0) ? '0 : ACC_MAX);
        end else if (r_big) begin
            res_sat = 1'b1;
            res     = r_neg ? ACC_MIN : ACC_MAX;
        end else if (r_neg) begin
            if (r_q > ACC_MIN) begin
                res_sat = 1'b1;
                res     = ACC_MIN;
            end else begin
                res = 32'd0 - r_q;
            end
        end else if (r_q[31]) begin
            res_sat = 1'b1;
            res     = ACC_MAX;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_lp[0] <= i_in.lander_pos_x;
            r_lp[1] <= i_in.lander_pos_y;
            r_lp[2] <= i_in.lander_pos_z;
            r_lv[0] <= i_in.lander_vel_x;
            r_lv[1] <= i_in.lander_vel_y;
            r_lv[2] <= i_in.lander_vel_z;
            r_tp[0] <= i_in.target_pos_x;
            r_tp[1] <= i_in.target_pos_y;
            r_tp[2] <= i_in.target_pos_z;
            r_tv[0] <= i_in.target_vel_x;
            r_tv[1] <= i_in.target_vel_y;
            r_tv[2] <= i_in.target_vel_z;
        end
        if (i_cmd.tgo) begin
            if (sum > {1'b0, i_cfg.final_time}) begin
                r_tgo <= i_cfg.final_time;
            end else begin
                r_tgo <= i_cfg.final_time - sum[31:0];
            end
        end
        if (i_cmd.t2) r_t2 <= mul_p[63:0];
        if (i_cmd.st_a || i_cmd.st_b || i_cmd.st_c) r_prod <= mul_p;
        if (i_cmd.st_a) r_acc <= d6_ext;
        if (i_cmd.st_b) r_acc <= r_acc - (prod_ext <<< SH1);
        if (i_cmd.st_c) r_acc <= r_acc - prod_ext;
        if (i_cmd.st_d) r_acc <= r_acc - (prod_ext <<< 32);
        if (i_cmd.st_e) begin
            r_neg <= r_acc[ACC_W-1];
            r_mag <= r_acc[ACC_W-1] ? ACC_W'(-r_acc) : ACC_W'(r_acc);
        end
        if (i_cmd.st_f) begin
            r_big <= r_mag >= {8'd0, r_t2, 32'd0};
            r_rem <= r_mag[95:32];
            r_lo  <= r_mag[31:0];
        end
        if (i_cmd.div) begin
            r_rem <= rem_ge ? rem_diff[63:0] : rem_sh[63:0];
            r_q   <= {r_q[30:0], rem_ge};
            r_lo  <= {r_lo[30:0], 1'b0};
        end
        if (i_cmd.store) r_res[i_cmd.axis] <= res;
        if (i_cmd.emit) begin
            r_out_ax  <= r_res[0];
            r_out_ay  <= r_res[1];
            r_out_az  <= r_res[2];
            r_out_tgo <= r_tgo;
            r_out_sat <= r_sat;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_elapsed   <= '0;
            r_sat       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.tgo) begin
                r_sat     <= 1'b0;
                r_elapsed <= (sum > {1'b0, i_cfg.final_time}) ? '0 : sum[31:0];
            end else if (i_cmd.store && res_sat) begin
                r_sat <= 1'b1;
            end
            if (i_cmd.emit) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_sts.out_free   = !r_out_valid || o_out.ready;
    assign o_out.valid      = r_out_valid;
    assign o_out.accel_x    = r_out_ax;
    assign o_out.accel_y    = r_out_ay;
    assign o_out.accel_z    = r_out_az;
    assign o_out.time_to_go = r_out_tgo;
    assign o_out.saturated  = r_out_sat;
endmodule
`default_nettype wire

// ===== src/zem_zev_guidance_accel.sv =====
// after an input transaction, time-to-go and its square are computed, then each axis is accumulated,
// divided and stored; one transaction is processed at a time, sequenced over the shared multiplier
// and the radix-2 divider that runs 32 steps for each of the three axes
// a new input is taken while the previous result waits in the output register
// reset: synchronous active low, clears elapsed time and control, sets config registers to defaults
`default_nettype none
module zem_zev_guidance_accel #(
    parameter int FRAC_BITS = zzg_pkg::FRAC_BITS_DEF
) (
    input  wire                         i_clk,
    input  wire                         i_rst_n,
    zzg_in_if.sink                      i_in,
    zzg_out_if.source                   o_out,
    input  wire                         psel,
    input  wire                         penable,
    input  wire                         pwrite,
    input  wire [zzg_pkg::ADDR_W-1:0]   paddr,
    input  wire [31:0]                  pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready
);
    import zzg_pkg::*;

    t_cfg r_cfg;
    t_cmd cmd;
    t_sts sts;
    logic in_ready;
    logic wr_en;
    logic [2:0] reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_idx = paddr[4:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.grav_x     <= '0;
            r_cfg.grav_y     <= '0;
            r_cfg.grav_z     <= '0;
            r_cfg.time_step  <= TIME_STEP_RST;
            r_cfg.final_time <= FINAL_TIME_RST;
        end else if (wr_en) begin
            case (reg_idx)
                REG_GRAV_X:     r_cfg.grav_x     <= pwdata;
                REG_GRAV_Y:     r_cfg.grav_y     <= pwdata;
                REG_GRAV_Z:     r_cfg.grav_z     <= pwdata;
                REG_TIME_STEP:  r_cfg.time_step  <= pwdata;
                REG_FINAL_TIME: r_cfg.final_time <= pwdata;
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            REG_GRAV_X:     prdata = r_cfg.grav_x;
            REG_GRAV_Y:     prdata = r_cfg.grav_y;
            REG_GRAV_Z:     prdata = r_cfg.grav_z;
            REG_TIME_STEP:  prdata = r_cfg.time_step;
            REG_FINAL_TIME: prdata = r_cfg.final_time;
            default:        prdata = '0;
        endcase
    end

    assign i_in.ready = in_ready;

    zzg_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_fire  (i_in.valid && in_ready),
        .i_sts      (sts),
        .o_in_ready (in_ready),
        .o_cmd      (cmd)
    );

    zzg_datapath #(
        .FRAC_BITS (FRAC_BITS)
    ) u_datapath (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_cmd   (cmd),
        .o_sts   (sts),
        .i_in    (i_in),
        .o_out   (o_out)
    );
endmodule
`default_nettype wire
